@@ src/delayed_request_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// delayed request tracker assertion macros
// shared property shorthands, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef DELAYED_REQUEST_TRACKER_MACROS_SVH
`define DELAYED_REQUEST_TRACKER_MACROS_SVH

// same-cycle implication
`define DRT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/drt_pkg.sv @@
// ----------------------------------------------------------------------------
// drt_pkg
// field widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package drt_pkg;

	localparam int unsigned MAX_RESULTS = 16;

	localparam int unsigned ID_W   = 32;
	localparam int unsigned TIME_W = 48;
	localparam int unsigned LAT_W  = 32;
	localparam int unsigned CAP_W  = 5;
	localparam int unsigned MAXC_W = 5;
	localparam int unsigned CFG_W  = 32;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// request commands
	localparam logic [1:0] OP_SUBMIT = 2'd0;
	localparam logic [1:0] OP_DRAIN  = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_SUBMIT = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;
	localparam logic [1:0] KIND_EMPTY  = 2'd3;

	// submit status
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_STOP = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_LATENCY  = 2'd0;
	localparam logic [1:0] REG_CAPACITY = 2'd1;
	localparam logic [1:0] REG_STOPPED  = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic       latch;
		logic       scan_start;
		logic       emit_submit;
		logic       emit_cancel;
		logic       drain_take;
		logic       drain_flush;
	} drt_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic more;
	} drt_stat_t;

endpackage

@@ src/drt_ram.sv @@
// ----------------------------------------------------------------------------
// drt_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module drt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/drt_ctrl.sv @@
// ----------------------------------------------------------------------------
// drt_ctrl
// request sequencer: accept, table scan, decision, repeat scans for drain
// ----------------------------------------------------------------------------
module drt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          op_in,
	input  drt_pkg::drt_stat_t  stat,
	output drt_pkg::drt_cmd_t   ctl,
	output logic                busy
);

	import drt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} state_t;

	state_t     state_q;
	logic [1:0] op_q;
	logic       busy_q;
	logic       accept;
	logic       decide;

	// command 3 is not taken and does nothing
	assign accept = (state_q == S_IDLE) && start && (op_in != OP_NONE);
	assign decide = (state_q == S_DECIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_SUBMIT;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= op_in;
						state_q <= S_SCAN;
						busy_q  <= 1'b1;
					end
				end
				S_SCAN: begin
					if (stat.scan_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if ((op_q == OP_DRAIN) && stat.more) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		ctl             = '0;
		ctl.op          = op_q;
		ctl.latch       = accept;
		ctl.emit_submit = decide && (op_q == OP_SUBMIT);
		ctl.emit_cancel = decide && (op_q == OP_CANCEL);
		ctl.drain_take  = decide && (op_q == OP_DRAIN) && stat.more;
		ctl.drain_flush = decide && (op_q == OP_DRAIN) && !stat.more;
		ctl.scan_start  = accept || ctl.drain_take;
	end

	assign busy = busy_q;

endmodule

@@ src/drt_dp.sv @@
// ----------------------------------------------------------------------------
// drt_dp
// slot table, scan pipeline, search registers and result register
// ----------------------------------------------------------------------------
module drt_dp #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  drt_pkg::drt_cmd_t             ctl,
	output drt_pkg::drt_stat_t            stat,
	input  logic [drt_pkg::ID_W-1:0]      req_id,
	input  logic [drt_pkg::TIME_W-1:0]    now,
	input  logic [drt_pkg::MAXC_W-1:0]    done_limit,
	input  logic [drt_pkg::LAT_W-1:0]     latency,
	input  logic [drt_pkg::CAP_W-1:0]     capacity,
	input  logic                          stopped,
	output logic                          strobe,
	output logic [1:0]                    kind,
	output logic [1:0]                    status,
	output logic [drt_pkg::ID_W-1:0]      done_id,
	output logic [drt_pkg::LAT_W-1:0]     reported_latency,
	output logic                          last
);

	import drt_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > int'(CAP_W)) ? CNT_W : int'(CAP_W);
	localparam int ENT_W = ID_W + TIME_W;

	// latched request
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;
	logic [MAXC_W-1:0] lim_q;
	logic [MAXC_W-1:0] lim_d;

	// scan pipeline
	logic             issue_q;
	logic [IDX_W-1:0] idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	// occupancy
	logic [DEPTH-1:0] valid_q;
	logic [CNT_W-1:0] cnt_q;

	// search results
	logic             dup_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             best_found_q;
	logic [ID_W-1:0]  best_id_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [MAXC_W-1:0] n_q;
	logic             pend_vld_q;
	logic [ID_W-1:0]  pend_id_q;

	// result register
	logic             strobe_q;
	logic [1:0]       kind_q;
	logic [1:0]       status_q;
	logic [ID_W-1:0]  done_id_q;
	logic [LAT_W-1:0] lat_q;
	logic             last_q;

	logic [ENT_W-1:0]  rdata;
	logic [ID_W-1:0]   rd_id;
	logic [TIME_W-1:0] rd_due;
	logic [TIME_W:0]   due_sum;
	logic [TIME_W-1:0] due;
	logic              slot_live;
	logic              hit;
	logic              cand;
	logic              full;
	logic              refuse;
	logic              submit_ok;

	drt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (submit_ok),
		.waddr (free_idx_q),
		.wdata ({id_q, due}),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign rd_id  = rdata[ENT_W-1 -: ID_W];
	assign rd_due = rdata[TIME_W-1:0];

	assign lim_d = (done_limit > MAXC_W'(MAX_RESULTS)) ?
		MAXC_W'(MAX_RESULTS) : done_limit;

	// due time saturates at the top of the time range
	assign due_sum = {1'b0, now_q} + (TIME_W + 1)'(latency);
	assign due     = due_sum[TIME_W] ? TIME_MAX : due_sum[TIME_W-1:0];

	assign slot_live = vld_s1 && valid_q[idx_s1];
	assign hit       = slot_live && (rd_id == id_q);
	assign cand      = slot_live && (ctl.op == OP_DRAIN) && (rd_due <= now_q) &&
		(!best_found_q || (rd_id < best_id_q));

	assign full = (CMP_W'(cnt_q) >= CMP_W'(capacity)) || (cnt_q == CNT_W'(DEPTH));
	assign refuse    = full || (id_q == '0) || dup_q;
	assign submit_ok = ctl.emit_submit && !stopped && !refuse;

	assign stat.scan_done = vld_s1 && (idx_s1 == IDX_W'(DEPTH - 1));
	assign stat.more      = best_found_q && (n_q < lim_q);

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			id_q  <= req_id;
			now_q <= now;
			lim_q <= lim_d;
		end
	end

	// read issue, one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
		end else if (ctl.scan_start) begin
			issue_q <= 1'b1;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= issue_q;
			if (issue_q) begin
				if (idx_q == IDX_W'(DEPTH - 1)) begin
					issue_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else if (submit_ok) begin
			valid_q[free_idx_q] <= 1'b1;
			cnt_q               <= cnt_q + 1'b1;
		end else if (ctl.drain_take) begin
			valid_q[best_idx_q] <= 1'b0;
			cnt_q               <= cnt_q - 1'b1;
		end else if ((ctl.op == OP_CANCEL) && hit) begin
			valid_q[idx_s1] <= 1'b0;
			cnt_q           <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			n_q          <= '0;
			pend_vld_q   <= 1'b0;
		end else begin
			if (ctl.latch) begin
				n_q        <= '0;
				pend_vld_q <= 1'b0;
			end
			if (ctl.scan_start) begin
				dup_q        <= 1'b0;
				free_found_q <= 1'b0;
				best_found_q <= 1'b0;
			end else begin
				if (hit) begin
					dup_q <= 1'b1;
				end
				if (vld_s1 && !valid_q[idx_s1]) begin
					free_found_q <= 1'b1;
				end
				if (cand) begin
					best_found_q <= 1'b1;
				end
			end
			if (ctl.drain_take) begin
				n_q        <= n_q + 1'b1;
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && !valid_q[idx_s1] && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (cand) begin
			best_id_q  <= rd_id;
			best_idx_q <= idx_s1;
		end
		if (ctl.drain_take) begin
			pend_id_q <= best_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.emit_submit || ctl.emit_cancel || ctl.drain_flush ||
				(ctl.drain_take && pend_vld_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_submit) begin
			kind_q    <= KIND_SUBMIT;
			status_q  <= stopped ? ST_STOP : (refuse ? ST_FULL : ST_OK);
			done_id_q <= '0;
			lat_q     <= '0;
			last_q    <= 1'b1;
		end else if (ctl.emit_cancel) begin
			kind_q    <= KIND_CANCEL;
			status_q  <= ST_OK;
			done_id_q <= '0;
			lat_q     <= '0;
			last_q    <= 1'b1;
		end else if (ctl.drain_take || (ctl.drain_flush && pend_vld_q)) begin
			// held completion goes out once it is known whether more follow
			kind_q    <= KIND_DONE;
			status_q  <= ST_OK;
			done_id_q <= pend_id_q;
			lat_q     <= latency;
			last_q    <= ctl.drain_flush;
		end else if (ctl.drain_flush) begin
			kind_q    <= KIND_EMPTY;
			status_q  <= ST_OK;
			done_id_q <= '0;
			lat_q     <= '0;
			last_q    <= 1'b1;
		end
	end

	assign strobe           = strobe_q;
	assign kind             = kind_q;
	assign status           = status_q;
	assign done_id          = done_id_q;
	assign reported_latency = lat_q;
	assign last             = last_q;

endmodule

@@ src/delayed_request_tracker.sv @@
// ----------------------------------------------------------------------------
// delayed_request_tracker
// table of outstanding requests that come due a fixed latency after submit
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every submit and
// cancel walks the whole slot table once, one slot per cycle through the
// slot memory's single read port, and the next request can be taken as
// soon as busy is low again. A drain walks the table once per completion
// plus one final walk. Results come out of a register, one per strobe
// cycle, and the receiver cannot hold them off: each result is valid for
// exactly one cycle. The last result of a request shows in the first cycle
// that busy is low again. Command 3 is not taken and gives no result.
// Configuration is to be written only while the block is idle; the user
// must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module delayed_request_tracker #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [drt_pkg::ID_W-1:0]      req_id,
	input  logic [drt_pkg::TIME_W-1:0]    now,
	input  logic [drt_pkg::MAXC_W-1:0]    done_limit,
	// configuration
	input  logic                          cfg_wen,
	input  logic [1:0]                    cfg_index,
	input  logic [drt_pkg::CFG_W-1:0]     cfg_data,
	// results
	output logic                          strobe,
	output logic [1:0]                    kind,
	output logic [1:0]                    status,
	output logic [drt_pkg::ID_W-1:0]      done_id,
	output logic [drt_pkg::LAT_W-1:0]     reported_latency,
	output logic                          last
);

	import drt_pkg::*;

	// configuration registers
	logic [LAT_W-1:0] latency_q;
	logic [CAP_W-1:0] capacity_q;
	logic             stopped_q;

	// controller to datapath
	drt_cmd_t  ctl;
	drt_stat_t stat;

	// plain write port, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latency_q  <= '0;
			capacity_q <= CAP_W'(16);
			stopped_q  <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_LATENCY:  latency_q  <= cfg_data[LAT_W-1:0];
				REG_CAPACITY: capacity_q <= cfg_data[CAP_W-1:0];
				REG_STOPPED:  stopped_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer: idle, scan, decide
	drt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op_in  (cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	// slot table, search and result register
	drt_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.stat             (stat),
		.req_id           (req_id),
		.now              (now),
		.done_limit       (done_limit),
		.latency          (latency_q),
		.capacity         (capacity_q),
		.stopped          (stopped_q),
		.strobe           (strobe),
		.kind             (kind),
		.status           (status),
		.done_id          (done_id),
		.reported_latency (reported_latency),
		.last             (last)
	);

	`include "delayed_request_tracker_macros.svh"

	// final result of a request only shows once the request is finished
	`DRT_ASSERT_IMP(a_last_idle, strobe && last, !busy, "final result while busy")
	// a drain result that is not the last keeps the block busy
	`DRT_ASSERT_IMP(a_more_busy, strobe && !last, busy, "non-final result while idle")
	// a real command keeps the block busy until its results are out
	`DRT_ASSERT_NXT(a_accept_busy, start && !busy && (cmd != OP_NONE), busy, "no busy on take")
	// stored ids are never zero
	`DRT_ASSERT_IMP(a_done_id, strobe && (kind == KIND_DONE), done_id != '0, "zero done id")

endmodule
